[src/sodo_pkg.sv]
// ----------------------------------------------------------------------------
// Swerve odometry package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sodo_pkg;

	localparam int CORDIC_STEPS_DEF = 20;
	localparam int WHEEL_W = 32;
	localparam int ANG_W = 32;
	localparam int POS_W = 48;
	localparam int SCALE_W = 24;
	localparam int CW = 34;

	localparam logic signed [ANG_W-1:0] TWO_PI_Q16 = 32'sd411775;
	localparam logic signed [ANG_W-1:0] PI_Q16 = 32'sd205887;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 32'sd102944;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	function automatic logic signed [CW-1:0] atan_q30(input logic [5:0] i);
		logic signed [CW-1:0] r;
		begin
			r = '0;
			case (i)
				6'd0: r = 34'sd843314857;
				6'd1: r = 34'sd497837829;
				6'd2: r = 34'sd263043837;
				6'd3: r = 34'sd133525159;
				6'd4: r = 34'sd67021687;
				6'd5: r = 34'sd33543516;
				6'd6: r = 34'sd16775851;
				6'd7: r = 34'sd8388437;
				6'd8: r = 34'sd4194283;
				6'd9: r = 34'sd2097149;
				6'd10: r = 34'sd1048576;
				default: begin
					if (i <= 6'd30) begin
						r = CW'(64'sd1 <<< (6'd30 - i));
					end
				end
			endcase
			return r;
		end
	endfunction

endpackage

[src/swerve_odometry_update.sv]
// ----------------------------------------------------------------------------
// Swerve odometry update
// Dead-reckoning pose update from gyro yaw, wheel totals and steering angles.
// ----------------------------------------------------------------------------
// Channel   Signals                                  Direction
// in        in_valid, in_stall, yaw_now, wheel_*, steer_*   into block
// out       out_valid, out_stall, pos_x, pos_y, heading     out of block
// cfg       cfg_valid, cfg_ready, cfg_data                  into block
//
// For each item, the scale product runs one multiplier bit per cycle, then the
// angle reduction runs, with correction steps when needed, then the CORDIC
// one iteration per cycle, and last each Q30 product one coefficient bit per
// cycle for both axes together. Reset clears the pose and the scale register.
// A finished pose waits in the pose registers while the next item is taken;
// that item's pose is held back until the previous one is taken.
// ----------------------------------------------------------------------------
module swerve_odometry_update #(
	parameter int CORDIC_STEPS = sodo_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] yaw_now,
	input  logic signed [31:0] wheel_fr,
	input  logic signed [31:0] wheel_bl,
	input  logic signed [31:0] wheel_fl,
	input  logic signed [31:0] wheel_br,
	input  logic signed [31:0] steer_fr,
	input  logic signed [31:0] steer_bl,
	input  logic signed [31:0] steer_fl,
	input  logic signed [31:0] steer_br,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [31:0] heading,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [23:0] cfg_data
);

	localparam int CW = sodo_pkg::CW;
	localparam logic signed [31:0] TWO_PI_Q16_S = sodo_pkg::TWO_PI_Q16;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_RED1, S_RED2, S_RED3, S_CORD, S_QMUL, S_DONE
	} state_t;

	state_t state_q;
	logic [23:0] scale_q;
	logic signed [47:0] prev_trans_q, est_x_q, est_y_q, delta_q;
	logic signed [31:0] prev_yaw_q, est_theta_q, yaw_q, ang_q;
	logic signed [33:0] wsum_q;
	logic [23:0] mbits_q;
	logic signed [58:0] macc_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic cstart_q;
	logic cdone;
	logic signed [CW-1:0] ccos, csin, kc_q, ks_q;
	logic signed [81:0] ax_q, ay_q;
	logic signed [33:0] ssum;
	logic signed [31:0] ang_next;
	logic signed [47:0] trans;

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ssum = 34'(steer_fr) + 34'(steer_bl) + 34'(steer_fl) + 34'(steer_br);
	assign ang_next = prev_yaw_q + 32'(ssum >>> 2);
	assign trans = macc_q[55:8];

	sodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart_q),
		.z_in(CW'(ang_q) <<< 14), .done(cdone), .cos_out(ccos), .sin_out(csin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scale_q <= '0;
			prev_trans_q <= '0;
			prev_yaw_q <= '0;
			est_x_q <= '0;
			est_y_q <= '0;
			est_theta_q <= '0;
			out_valid <= 1'b0;
			cstart_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			cstart_q <= 1'b0;
			if (cfg_valid) begin
				scale_q <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						wsum_q <= 34'(wheel_fr) + 34'(wheel_bl) + 34'(wheel_fl)
							+ 34'(wheel_br);
						mbits_q <= scale_q;
						macc_q <= '0;
						cnt_q <= '0;
						yaw_q <= yaw_now;
						ang_q <= ang_next;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mbits_q[0]) begin
						macc_q <= macc_q + (59'(wsum_q) <<< cnt_q);
					end
					mbits_q <= mbits_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd23) begin
						state_q <= S_RED1;
					end
				end
				S_RED1: begin
					delta_q <= trans - prev_trans_q;
					prev_trans_q <= trans;
					// Remainder of a flooring mod: at most a few thousand turns
					// would be too many steps, so use the signed reciprocal form.
					ang_q <= ang_q - 32'((64'(ang_q) * 64'sd10430) >>> 32) * TWO_PI_Q16_S;
					state_q <= S_RED2;
				end
				S_RED2: begin
					if (ang_q >= TWO_PI_Q16_S) begin
						ang_q <= ang_q - TWO_PI_Q16_S;
					end else if (ang_q < 0) begin
						ang_q <= ang_q + TWO_PI_Q16_S;
					end else begin
						state_q <= S_RED3;
					end
				end
				S_RED3: begin
					if (ang_q > sodo_pkg::PI_Q16) begin
						ang_q <= ang_q - TWO_PI_Q16_S;
					end else if (ang_q > sodo_pkg::HALF_PI_Q16) begin
						ang_q <= ang_q - sodo_pkg::PI_Q16;
						neg_q <= 1'b1;
						cstart_q <= 1'b1;
						state_q <= S_CORD;
					end else if (ang_q < -sodo_pkg::HALF_PI_Q16) begin
						ang_q <= ang_q + sodo_pkg::PI_Q16;
						neg_q <= 1'b1;
						cstart_q <= 1'b1;
						state_q <= S_CORD;
					end else begin
						neg_q <= 1'b0;
						cstart_q <= 1'b1;
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cdone) begin
						kc_q <= neg_q ? -ccos : ccos;
						ks_q <= neg_q ? -csin : csin;
						ax_q <= '0;
						ay_q <= '0;
						cnt_q <= '0;
						state_q <= S_QMUL;
					end
				end
				S_QMUL: begin
					if (cnt_q == 6'(CW - 1)) begin
						ax_q <= kc_q[0] ? ax_q - (82'(delta_q) <<< cnt_q) : ax_q;
						ay_q <= ks_q[0] ? ay_q - (82'(delta_q) <<< cnt_q) : ay_q;
						state_q <= S_DONE;
					end else begin
						ax_q <= kc_q[0] ? ax_q + (82'(delta_q) <<< cnt_q) : ax_q;
						ay_q <= ks_q[0] ? ay_q + (82'(delta_q) <<< cnt_q) : ay_q;
					end
					kc_q <= kc_q >>> 1;
					ks_q <= ks_q >>> 1;
					cnt_q <= cnt_q + 6'd1;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						est_x_q <= est_x_q + ax_q[77:30];
						est_y_q <= est_y_q + ay_q[77:30];
						est_theta_q <= est_theta_q + yaw_q - prev_yaw_q;
						prev_yaw_q <= yaw_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pos_x = est_x_q;
	assign pos_y = est_y_q;
	assign heading = est_theta_q;

endmodule

[src/sodo_cordic.sv]
// ----------------------------------------------------------------------------
// Swerve odometry CORDIC
// Rotation-mode CORDIC, one iteration per cycle, giving cos and sin in signed Q4.30.
// ----------------------------------------------------------------------------
module sodo_cordic #(
	parameter int CORDIC_STEPS = sodo_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [sodo_pkg::CW-1:0] z_in,
	output logic done,
	output logic signed [sodo_pkg::CW-1:0] cos_out,
	output logic signed [sodo_pkg::CW-1:0] sin_out
);

	localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

	logic busy_q;
	logic [5:0] i_q;
	logic signed [sodo_pkg::CW-1:0] x_q, y_q, z_q;
	logic signed [sodo_pkg::CW-1:0] xs, ys, at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = sodo_pkg::atan_q30(i_q);
	assign cos_out = x_q;
	assign sin_out = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				x_q <= sodo_pkg::CORDIC_GAIN_Q30;
				y_q <= '0;
				z_q <= z_in;
			end else if (busy_q) begin
				if (!z_q[sodo_pkg::CW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				i_q <= i_q + 6'd1;
				if (i_q == 6'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

endmodule
